/* hdl/page_framebuffer_text_renderer_defines.svh */
// assertion macros for the framebuffer text renderer
`ifndef PAGE_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PFT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pftr_pkg.sv */
package pftr_pkg;

  localparam int unsigned ScreenColumns = 128;
  localparam int unsigned ScreenRows    = 64;
  localparam int unsigned StoreBytes    = ScreenColumns * ScreenRows / 8;
  localparam int unsigned AddrW         = $clog2(StoreBytes);
  localparam int unsigned ColW          = $clog2(ScreenColumns) + 1;
  localparam int unsigned PageShift     = $clog2(ScreenColumns);
  localparam int unsigned GlyphCount    = 106;

  localparam logic [7:0] FirstCode = 8'd22;
  localparam logic [7:0] LastCode  = 8'd127;
  localparam logic [7:0] CodeA     = 8'h1C;
  localparam logic [7:0] CodeB     = 8'h1D;
  localparam logic [7:0] CodeC     = 8'h1A;

  typedef enum logic [2:0] {
    CmdPutChar = 3'd0,
    CmdNewline = 3'd1,
    CmdSetPixel = 3'd2,
    CmdClear = 3'd3,
    CmdPicStart = 3'd4,
    CmdPicByte = 3'd5,
    CmdRead = 3'd6,
    CmdNone = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    PhFirst = 2'd0,
    PhLook  = 2'd1,
    PhCount = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StRead,
    StModify,
    StRun,
    StReadOut
  } state_e;

  localparam logic [7:0] GlyphRom [0:GlyphCount*3-1] = '{
    8'h30,8'h0C,8'h02, 8'h38,8'h20,8'h38, 8'h0A,8'h0F,8'h02, 8'h05,8'h0F,8'h04,
    8'h00,8'h00,8'h38, 8'h18,8'h08,8'h38, 8'h30,8'h0C,8'h02, 8'h28,8'h3E,8'h00,
    8'h18,8'h20,8'h18, 8'h38,8'h26,8'h38,
    8'h00,8'h00,8'h00, 8'h00,8'h2E,8'h00, 8'h06,8'h00,8'h06, 8'h3E,8'h14,8'h3E,
    8'h14,8'h3F,8'h0A, 8'h12,8'h08,8'h24, 8'h14,8'h2A,8'h34, 8'h00,8'h06,8'h00,
    8'h1C,8'h22,8'h00, 8'h22,8'h1C,8'h00, 8'h1C,8'h1C,8'h1C, 8'h08,8'h1C,8'h08,
    8'h40,8'h20,8'h00, 8'h08,8'h08,8'h08, 8'h00,8'h20,8'h00, 8'h10,8'h08,8'h04,
    8'h1C,8'h22,8'h1C, 8'h24,8'h3E,8'h20, 8'h32,8'h2A,8'h24, 8'h22,8'h2A,8'h14,
    8'h0E,8'h08,8'h3E, 8'h2E,8'h2A,8'h12, 8'h3E,8'h2A,8'h3A, 8'h02,8'h3A,8'h06,
    8'h3E,8'h2A,8'h3E, 8'h2E,8'h2A,8'h3E, 8'h00,8'h14,8'h00, 8'h20,8'h14,8'h00,
    8'h08,8'h14,8'h22, 8'h14,8'h14,8'h14, 8'h22,8'h14,8'h08, 8'h02,8'h2A,8'h04,
    8'h1C,8'h26,8'h2E, 8'h3C,8'h0A,8'h3C, 8'h3E,8'h2A,8'h14, 8'h1C,8'h22,8'h22,
    8'h3E,8'h22,8'h1C, 8'h3E,8'h2A,8'h22, 8'h3E,8'h0A,8'h02, 8'h1C,8'h22,8'h1A,
    8'h3E,8'h08,8'h3E, 8'h22,8'h3E,8'h22, 8'h10,8'h20,8'h1E, 8'h3E,8'h08,8'h36,
    8'h3E,8'h20,8'h20, 8'h3E,8'h04,8'h3E, 8'h3E,8'h02,8'h3E, 8'h3E,8'h22,8'h3E,
    8'h3E,8'h0A,8'h04, 8'h1C,8'h22,8'h3C, 8'h3E,8'h0A,8'h34, 8'h24,8'h2A,8'h12,
    8'h02,8'h3E,8'h02, 8'h3E,8'h20,8'h3E, 8'h1E,8'h20,8'h1E, 8'h3E,8'h10,8'h3E,
    8'h36,8'h08,8'h36, 8'h0E,8'h30,8'h0E, 8'h32,8'h2A,8'h26, 8'h00,8'h3E,8'h22,
    8'h04,8'h08,8'h10, 8'h22,8'h3E,8'h00, 8'h04,8'h02,8'h04, 8'h40,8'h40,8'h40,
    8'h02,8'h04,8'h00, 8'h34,8'h2C,8'h38, 8'h3E,8'h24,8'h18, 8'h18,8'h24,8'h24,
    8'h18,8'h24,8'h3E, 8'h18,8'h34,8'h2C, 8'h08,8'h3C,8'h0A, 8'h58,8'h54,8'h3C,
    8'h3E,8'h04,8'h38, 8'h00,8'h3A,8'h00, 8'h40,8'h3A,8'h00, 8'h3E,8'h18,8'h24,
    8'h00,8'h1E,8'h20, 8'h3C,8'h0C,8'h3C, 8'h3C,8'h04,8'h38, 8'h18,8'h24,8'h18,
    8'h7C,8'h24,8'h18, 8'h18,8'h24,8'h7C, 8'h38,8'h04,8'h04, 8'h28,8'h3C,8'h14,
    8'h04,8'h3E,8'h24, 8'h3C,8'h20,8'h3C, 8'h1C,8'h20,8'h1C, 8'h3C,8'h30,8'h3C,
    8'h24,8'h18,8'h24, 8'h0C,8'h50,8'h3C, 8'h34,8'h3C,8'h2C, 8'h08,8'h36,8'h22,
    8'h00,8'h36,8'h00, 8'h22,8'h36,8'h08, 8'h04,8'h06,8'h02, 8'h3E,8'h3E,8'h3E
  };

endpackage

/* hdl/page_framebuffer_text_renderer.sv */
// Page framebuffer text renderer: 1024-byte monochrome store, eight vertical
// pixels per byte, 128 columns per page. Commands are taken when start_i is
// high and busy_o low; busy_o stays high while one command is worked on. After
// reset the store is swept to zero, one byte a cycle, with busy_o high for the
// whole sweep. Every text or pixel store update is a read-modify-write through
// the single memory port. A put-character makes 4 updates (3 glyph columns
// plus an extra or gap column), clear sweeps one byte a cycle and a picture
// run of c bytes writes c bytes (a count of 0 runs 256 bytes). Newline,
// picture start, a single picture byte and codes that draw nothing leave busy_o
// low, so such items can be taken on every edge. The read result is shown on
// read_data_o for one cycle with done_o high, registered in rdata_q and then in
// out_q; the receiver cannot stall it, so it must take it in that cycle.
// inverse_text is written through cfg_we_i/cfg_wdata_i; the user must do this
// only while the block is idle, which the block itself leaves unchecked.
module page_framebuffer_text_renderer
  import pftr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  picture_byte_i,
  input  logic [9:0]  read_address_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        done_o,
  output logic [7:0]  read_data_o
);

  // frame memory, one port
  logic [7:0] mem_q [0:StoreBytes-1];
  logic [7:0] rdata_q;
  logic [AddrW-1:0] maddr;
  logic [7:0] mwdata;
  logic mwe;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem_q[maddr] <= mwdata;
    end
    rdata_q <= mem_q[maddr];
  end

  state_e state_q, state_d;
  logic inv_q;
  logic [7:0] col_q, col_d;        // cursor column
  logic [7:0] page_q, page_d;
  logic [AddrW:0] ptr_q, ptr_d;    // picture pointer
  phase_e phase_q, phase_d;
  logic [7:0] runv_q, runv_d;
  // per-item working registers
  logic [AddrW:0] waddr_q, waddr_d; // sweep / current byte address
  logic [8:0] cnt_q, cnt_d;         // run length of a picture run
  logic [2:0] step_q, step_d;       // column step of a character
  logic [8:0] ccol_q, ccol_d;       // working column of a character
  logic [8:0] gidx_q, gidx_d;       // glyph rom base
  logic [7:0] code_q, code_d;
  logic [7:0] mask_q, mask_d;
  logic on_q, on_d;
  logic is_pix_q, is_pix_d;
  logic done_q, done_d;
  logic [7:0] out_q, out_d;

  // text byte address: page*128+column, 18 bits max
  logic [17:0] taddr;
  logic [7:0] colv;
  logic colw;                        // column is written this step
  logic [7:0] gdat_q;                // glyph column, read alongside the store

  assign taddr = ({10'd0, page_q} << PageShift) + {9'd0, ccol_q};

  // glyph rom read registered in the same cycle as the store read
  always_ff @(posedge clk_i) begin
    gdat_q <= GlyphRom[gidx_q + {6'd0, step_q}];
  end

  always_comb begin
    colw = 1'b1;
    colv = inv_q ? ~(gdat_q | 8'h80) : gdat_q;
    if (step_q == 3'd3) begin
      if (code_q == CodeA) begin
        colv = 8'h30;
      end else if (code_q == CodeB) begin
        colv = 8'h38;
      end else if (code_q == CodeC) begin
        colv = 8'h08;
      end else begin
        colv = inv_q ? 8'h7F : 8'h00;
        colw = (ccol_q < 9'(ScreenColumns));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      inv_q <= 1'b0;
      col_q <= '0;
      page_q <= '0;
      ptr_q <= '0;
      phase_q <= PhFirst;
      runv_q <= '0;
      waddr_q <= '0;
      cnt_q <= '0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      col_q <= col_d;
      page_q <= page_d;
      ptr_q <= ptr_d;
      phase_q <= phase_d;
      runv_q <= runv_d;
      waddr_q <= waddr_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ccol_q <= ccol_d;
    gidx_q <= gidx_d;
    code_q <= code_d;
    mask_q <= mask_d;
    on_q <= on_d;
    is_pix_q <= is_pix_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    col_d = col_q;
    page_d = page_q;
    ptr_d = ptr_q;
    phase_d = phase_q;
    runv_d = runv_q;
    waddr_d = waddr_q;
    cnt_d = cnt_q;
    step_d = step_q;
    ccol_d = ccol_q;
    gidx_d = gidx_q;
    code_d = code_q;
    mask_d = mask_q;
    on_d = on_q;
    is_pix_d = is_pix_q;
    out_d = out_q;
    done_d = 1'b0;
    maddr = waddr_q[AddrW-1:0];
    mwdata = 8'h00;
    mwe = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CmdPutChar: begin
              if (char_code_i >= FirstCode && char_code_i <= LastCode) begin
                code_d = char_code_i;
                gidx_d = 9'(({1'b0, char_code_i} - 9'(FirstCode)) * 9'd3);
                ccol_d = {1'b0, col_q};
                step_d = '0;
                is_pix_d = 1'b0;
                state_d = StRead;
              end
            end
            CmdNewline: begin
              col_d = '0;
              page_d = page_q + 8'd1;
            end
            CmdSetPixel: begin
              if (pixel_x_i < 8'(ScreenColumns) && pixel_y_i < 8'(ScreenRows)) begin
                waddr_d = (AddrW+1)'(({11'd0, pixel_y_i[7:3]} << PageShift)
                                     + {8'd0, pixel_x_i});
                mask_d = 8'd1 << pixel_y_i[2:0];
                on_d = pixel_on_i;
                is_pix_d = 1'b1;
                state_d = StRead;
              end
            end
            CmdClear: begin
              col_d = '0;
              page_d = '0;
              waddr_d = '0;
              state_d = StClear;
            end
            CmdPicStart: begin
              ptr_d = '0;
              phase_d = PhFirst;
            end
            CmdPicByte: begin
              if (ptr_q < (AddrW+1)'(StoreBytes)) begin
                case (phase_q)
                  PhLook: begin
                    if (picture_byte_i == runv_q) begin
                      phase_d = PhCount;
                    end else begin
                      mwe = 1'b1;
                      maddr = ptr_q[AddrW-1:0];
                      mwdata = runv_q;
                      ptr_d = ptr_q + (AddrW+1)'(1);
                      runv_d = picture_byte_i;
                    end
                  end
                  PhCount: begin
                    cnt_d = (picture_byte_i == 8'd0) ? 9'd256 : {1'b0, picture_byte_i};
                    phase_d = PhFirst;
                    state_d = StRun;
                  end
                  default: begin
                    runv_d = picture_byte_i;
                    phase_d = PhLook;
                  end
                endcase
              end
            end
            CmdRead: begin
              maddr = read_address_i[AddrW-1:0];
              state_d = StReadOut;
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        mwe = 1'b1;
        mwdata = 8'h00;
        waddr_d = waddr_q + (AddrW+1)'(1);
        if (waddr_q == (AddrW+1)'(StoreBytes - 1)) begin
          waddr_d = '0;
          state_d = StIdle;
        end
      end
      StRun: begin
        if (cnt_q == 9'd0 || ptr_q >= (AddrW+1)'(StoreBytes)) begin
          state_d = StIdle;
        end else begin
          mwe = 1'b1;
          maddr = ptr_q[AddrW-1:0];
          mwdata = runv_q;
          ptr_d = ptr_q + (AddrW+1)'(1);
          cnt_d = cnt_q - 9'd1;
        end
      end
      StRead: begin
        // issue memory read for the target byte
        if (!is_pix_q) begin
          maddr = taddr[AddrW-1:0];
        end
        state_d = StModify;
      end
      StModify: begin
        if (is_pix_q) begin
          mwe = 1'b1;
          mwdata = on_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
          state_d = StIdle;
        end else begin
          maddr = taddr[AddrW-1:0];
          mwdata = rdata_q | colv;
          mwe = colw && (taddr < 18'(StoreBytes));
          ccol_d = ccol_q + (colw ? 9'd1 : 9'd0)
                   + ((step_q == 3'd3 && code_q == CodeB) ? 9'd1 : 9'd0);
          if (step_q == 3'd3) begin
            if (ccol_d >= 9'(ScreenColumns)) begin
              col_d = '0;
              page_d = page_q + 8'd1;
            end else begin
              col_d = ccol_d[7:0];
            end
            state_d = StIdle;
          end else begin
            step_d = step_q + 3'd1;
            state_d = StRead;
          end
        end
      end
      StReadOut: begin
        out_d = rdata_q;
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign read_data_o = out_q;

endmodule

/* hdl/pftr_checker.sv */
`include "page_framebuffer_text_renderer_defines.svh"
module pftr_checker
  import pftr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] command_i,
  input logic       done_o
);

  logic rd_take;
  assign rd_take = start_i && !busy_o && command_i == CmdRead;

  // a read keeps busy_o high and is answered by a done_o strobe
  `PFT_ASSERT_NEXT(a_read_busy, clk_i, rst_ni, rd_take, busy_o, "read not busy")
  `PFT_ASSERT(a_read_done, clk_i, rst_ni, rd_take |-> ##2 done_o, "read result missing")
  // a result strobe is single and never comes while busy
  `PFT_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "repeated result")
  `PFT_ASSERT(a_done_idle, clk_i, rst_ni, !done_o || !busy_o, "result while busy")

endmodule

bind page_framebuffer_text_renderer pftr_checker u_pftr_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start_i(start_i),
  .busy_o(busy_o),
  .command_i(command_i),
  .done_o(done_o)
);

/* bench/page_framebuffer_text_renderer_tb.sv */
`timescale 1ns / 1ps

module page_framebuffer_text_renderer_tb;
  import pftr_pkg::*;

  // stimulus row: command fields plus an optional hand-typed expected byte
  typedef struct {
    cmd_e       cmd;
    logic [7:0] code;
    logic [7:0] px;
    logic [7:0] py;
    logic       on;
    logic [7:0] pb;
    logic [9:0] ra;
    logic       has_fixed;
    logic [7:0] fixed;
  } item_t;

  localparam int unsigned CycleLimit = 1500000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [2:0] command_i = '0;
  logic [7:0] char_code_i = '0;
  logic [7:0] pixel_x_i = '0;
  logic [7:0] pixel_y_i = '0;
  logic       pixel_on_i = 1'b0;
  logic [7:0] picture_byte_i = '0;
  logic [9:0] read_address_i = '0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       busy_o;
  logic       done_o;
  logic [7:0] read_data_o;

  // predictor copy of the block state
  logic [7:0]  shadow_store [0:StoreBytes-1];
  logic [7:0]  cur_col;
  logic [7:0]  cur_page;
  int unsigned pic_ptr;
  phase_e      pic_phase;
  logic [7:0]  pic_value;
  logic        inv_mode;

  logic [7:0] read_queue [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit         quiet_mode = 1'b0;

  page_framebuffer_text_renderer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .char_code_i    (char_code_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .picture_byte_i (picture_byte_i),
    .read_address_i (read_address_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("page_framebuffer_text_renderer verification failed");
      $finish;
    end
  end

  // result checker, sampled at the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (read_queue.size() == 0) begin
        $display("%0t: unexpected read result %h", $time, read_data_o);
        error_count <= error_count + 1;
      end else begin
        if (read_data_o !== read_queue[0]) begin
          $display("%0t: read_data expected %h actual %h", $time, read_queue[0],
                   read_data_o);
          error_count <= error_count + 1;
        end
        void'(read_queue.pop_front());
      end
    end
  end

  function automatic void store_or(int unsigned addr, logic [7:0] v);
    if (addr < StoreBytes) shadow_store[addr] = shadow_store[addr] | v;
  endfunction

  function automatic void render_char(logic [7:0] code);
    int unsigned col;
    int unsigned base;
    int unsigned g;
    logic [7:0]  d;
    col = cur_col;
    base = cur_page * ScreenColumns;
    if (code < FirstCode || code > LastCode) return;
    g = (code - FirstCode) * 3;
    for (int k = 0; k < 3; k++) begin
      d = GlyphRom[g + k];
      if (inv_mode) d = ~(d | 8'h80);
      store_or(base + col, d);
      col++;
    end
    if (code == CodeA) begin
      store_or(base + col, 8'h30);
      col++;
    end else if (code == CodeB) begin
      store_or(base + col, 8'h38);
      col += 2;
    end else if (code == CodeC) begin
      store_or(base + col, 8'h08);
      col++;
    end else if (col < ScreenColumns) begin
      store_or(base + col, inv_mode ? 8'h7F : 8'h00);
      col++;
    end
    if (col >= ScreenColumns) begin
      col = 0;
      cur_page = cur_page + 8'd1;
    end
    cur_col = col[7:0];
  endfunction

  function automatic void picture_fill(logic [7:0] v, int unsigned times);
    while (times > 0 && pic_ptr < StoreBytes) begin
      shadow_store[pic_ptr] = v;
      pic_ptr++;
      times--;
    end
  endfunction

  function automatic void decode_picture(logic [7:0] b);
    if (pic_ptr >= StoreBytes) return;
    case (pic_phase)
      PhLook: begin
        if (b == pic_value) pic_phase = PhCount;
        else begin
          picture_fill(pic_value, 1);
          pic_value = b;
        end
      end
      PhCount: begin
        picture_fill(pic_value, b == 8'd0 ? 256 : b);
        pic_phase = PhFirst;
      end
      default: begin
        pic_value = b;
        pic_phase = PhLook;
      end
    endcase
  endfunction

  // returns 1 with the byte a read yields
  function automatic bit predict_item(item_t it, output logic [7:0] rd);
    int unsigned a;
    rd = '0;
    case (it.cmd)
      CmdPutChar: render_char(it.code);
      CmdNewline: begin
        cur_col = '0;
        cur_page = cur_page + 8'd1;
      end
      CmdSetPixel: begin
        if (it.px < ScreenColumns && it.py < ScreenRows) begin
          a = it.px + (it.py >> 3) * ScreenColumns;
          if (it.on) shadow_store[a] = shadow_store[a] | (8'd1 << it.py[2:0]);
          else shadow_store[a] = shadow_store[a] & ~(8'd1 << it.py[2:0]);
        end
      end
      CmdClear: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        cur_col = '0;
        cur_page = '0;
      end
      CmdPicStart: begin
        pic_ptr = 0;
        pic_phase = PhFirst;
      end
      CmdPicByte: decode_picture(it.pb);
      CmdRead: begin
        rd = (it.ra < StoreBytes) ? shadow_store[it.ra] : 8'h00;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic item_t mk(cmd_e c, logic [7:0] code = '0, logic [7:0] px = '0,
                               logic [7:0] py = '0, logic on = 1'b0, logic [7:0] pb = '0,
                               logic [9:0] ra = '0, logic hf = 1'b0, logic [7:0] fx = '0);
    item_t it;
    it.cmd = c; it.code = code; it.px = px; it.py = py; it.on = on;
    it.pb = pb; it.ra = ra; it.has_fixed = hf; it.fixed = fx;
    return it;
  endfunction

  // wait out a random sender gap, then present the item until accepted
  task automatic send_item(item_t it);
    logic [7:0] rd;
    item_t      r;
    int unsigned gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    r = it;
    if (predict_item(it, rd)) read_queue.push_back(it.has_fixed ? it.fixed : rd);
    start_i <= 1'b1;
    command_i <= r.cmd;
    char_code_i <= r.code;
    pixel_x_i <= r.px;
    pixel_y_i <= r.py;
    pixel_on_i <= r.on;
    picture_byte_i <= r.pb;
    read_address_i <= r.ra;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // register write only once the block has drained
  task automatic write_inverse(logic v);
    start_i <= 1'b0;
    while (read_queue.size() != 0 || busy_o) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    inv_mode = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic item_t random_item();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return mk(CmdPutChar, ($urandom_range(0, 9) == 0)
                            ? 8'($urandom_range(0, 255)) : 8'($urandom_range(22, 127)));
    if (sel < 34) return mk(CmdNewline);
    if (sel < 50) return mk(CmdSetPixel, 8'd0,
                            ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                            : 8'($urandom_range(0, 127)),
                            ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                            : 8'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    if (sel < 51) return mk(CmdClear);
    if (sel < 55) return mk(CmdNone, 8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom_range(0, 1)), 8'($urandom), 10'($urandom));
    return mk(CmdRead, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'($urandom_range(0, 1023)));
  endfunction

  // a short coded picture: singles and runs, mostly small counts
  task automatic send_picture(int unsigned tokens);
    logic [7:0] v;
    logic [7:0] last;
    send_item(mk(CmdPicStart));
    last = 8'h00;
    for (int unsigned t = 0; t < tokens; t++) begin
      v = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        send_item(mk(CmdPicByte, 0, 0, 0, 0, v));
        send_item(mk(CmdPicByte, 0, 0, 0, 0, v));
        send_item(mk(CmdPicByte, 0, 0, 0, 0,
                     ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 40))));
      end else begin
        if (v == last) v = v + 8'd1;
        send_item(mk(CmdPicByte, 0, 0, 0, 0, v));
      end
      last = v;
    end
  endtask

  item_t directed [$];

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    cur_col = '0;
    cur_page = '0;
    pic_ptr = 0;
    pic_phase = PhFirst;
    pic_value = '0;
    inv_mode = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the store reads zero at both ends
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd0, 1'b1, 8'h00));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd1023, 1'b1, 8'h00));
    // first and last drawable codes, out of range codes, special columns
    directed.push_back(mk(CmdPutChar, FirstCode));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd0, 1'b1, 8'h30));
    directed.push_back(mk(CmdPutChar, LastCode));
    directed.push_back(mk(CmdPutChar, 8'd21));
    directed.push_back(mk(CmdPutChar, 8'd128));
    directed.push_back(mk(CmdPutChar, 8'd255));
    directed.push_back(mk(CmdPutChar, CodeA));
    directed.push_back(mk(CmdPutChar, CodeB));
    directed.push_back(mk(CmdPutChar, CodeC));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd11));
    directed.push_back(mk(CmdNewline));
    directed.push_back(mk(CmdPutChar, 8'd65));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd128));
    // pixel corners, off screen and clearing
    directed.push_back(mk(CmdSetPixel, 0, 8'd127, 8'd63, 1'b1));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd1023, 1'b1, 8'h80));
    directed.push_back(mk(CmdSetPixel, 0, 8'd128, 8'd0, 1'b1));
    directed.push_back(mk(CmdSetPixel, 0, 8'd0, 8'd255, 1'b1));
    directed.push_back(mk(CmdSetPixel, 0, 8'd127, 8'd63, 1'b0));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd1023, 1'b1, 8'h00));
    directed.push_back(mk(CmdNone, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 10'h3FF));
    directed.push_back(mk(CmdClear));
    directed.push_back(mk(CmdRead, 0, 0, 0, 0, 0, 10'd0, 1'b1, 8'h00));
    foreach (directed[i]) send_item(directed[i]);

    // inverse text, then text that wraps onto the next page
    write_inverse(1'b1);
    for (int i = 0; i < 40; i++) send_item(mk(CmdPutChar, 8'($urandom_range(22, 127))));
    for (int i = 0; i < 6; i++) send_item(random_item());
    write_inverse(1'b0);

    // picture filling the whole store with count 0 runs, then past the end
    send_item(mk(CmdPicStart));
    for (int i = 0; i < 5; i++) begin
      send_item(mk(CmdPicByte, 0, 0, 0, 0, 8'(8'hA5 + i)));
      send_item(mk(CmdPicByte, 0, 0, 0, 0, 8'(8'hA5 + i)));
      send_item(mk(CmdPicByte, 0, 0, 0, 0, 8'd0));
    end
    send_item(mk(CmdRead, 0, 0, 0, 0, 0, 10'd1023, 1'b1, 8'hA8));
    send_item(mk(CmdPicByte, 0, 0, 0, 0, 8'h00));

    // random phases with both register settings
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 39) == 0) send_picture($urandom_range(2, 12));
        else if ($urandom_range(0, 99) < 2) begin
          // free-running page overflow burst
          for (int n = 0; n < 30; n++) send_item(mk(CmdNewline));
        end else send_item(random_item());
        if (ph == 5 && i == 60) quiet_mode = 1'b1;
      end
      if (ph < 5) write_inverse(ph[0] ? 1'b0 : 1'b1);
    end

    start_i <= 1'b0;
    while (read_queue.size() != 0 || busy_o) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (error_count == 0 && read_queue.size() == 0) begin
      $display("page_framebuffer_text_renderer verification clean");
    end else begin
      $display("page_framebuffer_text_renderer verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/pftr_pkg.sv
hdl/page_framebuffer_text_renderer.sv
hdl/pftr_checker.sv
bench/page_framebuffer_text_renderer_tb.sv
